FILE: rtl/core/itdd_pkg.sv
// ----------------------------------------------------------------------------
// itdd_pkg
// Shared types and constants for the integer to decimal digits block.
// ----------------------------------------------------------------------------
package itdd_pkg;

  localparam int unsigned VALUE_W       = 61;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned BCD_DIGITS    = 19;
  localparam int unsigned BCD_W         = BCD_DIGITS * DIGIT_W;
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned CONV_STEPS    = (VALUE_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned BIN_W         = CONV_STEPS * BITS_PER_STEP;
  localparam int unsigned CONV_CNT_W    = $clog2(CONV_STEPS);
  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [VALUE_W-1:0] SPLIT_BIG = VALUE_W'(64'd10000000000000000);
  localparam logic [VALUE_W-1:0] SMALL_MAX = VALUE_W'(64'd2147483647);

  localparam logic [COUNT_W-1:0] LOW_W_SMALL = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] LOW_W_MID   = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] LOW_W_BIG   = COUNT_W'(9);

  typedef enum logic [1:0] {
    CLS_SMALL,
    CLS_MID,
    CLS_BIG
  } cls_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_SIZE,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    cls_e               cls;
  } entry_t;

endpackage

FILE: rtl/core/itdd_front.sv
// ----------------------------------------------------------------------------
// itdd_front
// Input stage: takes items, drops zero, tags each with its split class.
// ----------------------------------------------------------------------------
module itdd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [itdd_pkg::VALUE_W-1:0] value_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output itdd_pkg::entry_t       push_entry_o
);
  import itdd_pkg::*;

  logic   vld_d, vld_q;
  entry_t entry_d, entry_q;
  logic   take;

  assign in_ready_o = !vld_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d   = vld_q && !push_ready_i;
    entry_d = entry_q;
    if (take && (value_i != '0)) begin
      vld_d         = 1'b1;
      entry_d.value = value_i;
      if (value_i >= SPLIT_BIG) begin
        entry_d.cls = CLS_BIG;
      end else if (value_i > SMALL_MAX) begin
        entry_d.cls = CLS_MID;
      end else begin
        entry_d.cls = CLS_SMALL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign push_valid_o = vld_q;
  assign push_entry_o = entry_q;

endmodule

FILE: rtl/core/itdd_fifo.sv
// ----------------------------------------------------------------------------
// itdd_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module itdd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  itdd_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output itdd_pkg::entry_t pop_entry_o
);
  import itdd_pkg::*;

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_d, cnt_q;
  logic                  push, pop;

  assign push_ready_o = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

FILE: rtl/core/itdd_back.sv
// ----------------------------------------------------------------------------
// itdd_back
// Back part: shift-add-3 conversion, digit count, serial digit output.
// ----------------------------------------------------------------------------
module itdd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_o,
  input  itdd_pkg::entry_t pop_entry_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [itdd_pkg::DIGIT_W-1:0] digit_o,
  output logic [itdd_pkg::COUNT_W-1:0] digit_count_o,
  output logic             last_o
);
  import itdd_pkg::*;

  back_state_e state_d, state_q;

  logic [BIN_W-1:0]                    bin_d, bin_q;
  logic [BCD_DIGITS-1:0][DIGIT_W-1:0]  bcd_d, bcd_q;
  logic [CONV_CNT_W-1:0]               step_d, step_q;
  cls_e                                cls_d, cls_q;
  logic [COUNT_W-1:0]                  n_d, n_q, pos_d, pos_q;

  logic                                out_vld_d, out_vld_q;
  logic [DIGIT_W-1:0]                  dig_d, dig_q;
  logic [COUNT_W-1:0]                  cnt_d, cnt_q;
  logic                                last_d, last_q;

  logic [BCD_DIGITS-1:0][DIGIT_W-1:0]  dab_bcd;
  logic [BIN_W-1:0]                    dab_bin;
  logic [BCD_W:0]                      dab_shift;
  logic [COUNT_W-1:0]                  nv, low_w, hi_w, grp_w, tot_w;

  // four bits of shift-add-3 per cycle
  always_comb begin
    dab_bcd   = bcd_q;
    dab_bin   = bin_q;
    dab_shift = '0;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (dab_bcd[d] >= DIGIT_W'(5)) begin
          dab_bcd[d] = dab_bcd[d] + DIGIT_W'(3);
        end
      end
      dab_shift = {dab_bcd, dab_bin[BIN_W-1]};
      dab_bcd   = dab_shift[BCD_W-1:0];
      dab_bin   = {dab_bin[BIN_W-2:0], 1'b0};
    end
  end

  // significant digits and total run length
  always_comb begin
    nv = '0;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (bcd_q[d] != '0) begin
        nv = COUNT_W'(d + 1);
      end
    end
    case (cls_q)
      CLS_BIG: low_w = LOW_W_BIG;
      CLS_MID: low_w = LOW_W_MID;
      default: low_w = LOW_W_SMALL;
    endcase
    hi_w  = nv - low_w;
    grp_w = (hi_w + COUNT_W'(3)) & ~COUNT_W'(3);
    tot_w = grp_w + low_w;
  end

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    step_d    = step_q;
    cls_d     = cls_q;
    n_d       = n_q;
    pos_d     = pos_q;
    out_vld_d = out_vld_q && !out_ready_i;
    dig_d     = dig_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    pop_o     = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          bin_d   = BIN_W'(pop_entry_i.value);
          bcd_d   = '0;
          step_d  = '0;
          cls_d   = pop_entry_i.cls;
          state_d = B_CONV;
        end
      end
      B_CONV: begin
        bin_d  = dab_bin;
        bcd_d  = dab_bcd;
        step_d = step_q + 1'b1;
        if (step_q == CONV_CNT_W'(CONV_STEPS - 1)) begin
          state_d = B_SIZE;
        end
      end
      B_SIZE: begin
        n_d     = tot_w;
        pos_d   = tot_w - 1'b1;
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (!out_vld_d) begin
          out_vld_d = 1'b1;
          dig_d     = (pos_q < COUNT_W'(BCD_DIGITS)) ? bcd_q[pos_q] : '0;
          cnt_d     = n_q;
          last_d    = pos_q == '0;
          pos_d     = pos_q - 1'b1;
          if (pos_q == '0) begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    step_q <= step_d;
    cls_q  <= cls_d;
    n_q    <= n_d;
    pos_q  <= pos_d;
    dig_q  <= dig_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign digit_o       = dig_q;
  assign digit_count_o = cnt_q;
  assign last_o        = last_q;

endmodule

FILE: rtl/core/integer_to_decimal_digits.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_digits
// Converts a positive integer to its decimal digits, most significant first.
// ----------------------------------------------------------------------------
// In the back part each item is dispatched, converted by the shift-add-3
// converter (four input bits per cycle over 64 bits), sized, then sent out
// one digit per cycle into the output register unless the output stalls.
// The front stage and a two-entry queue accept up to three further items
// while a conversion runs. A value of zero produces no digits.
module integer_to_decimal_digits (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [itdd_pkg::VALUE_W-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [itdd_pkg::DIGIT_W-1:0] digit_o,
  output logic [itdd_pkg::COUNT_W-1:0] digit_count_o,
  output logic                         last_o
);
  import itdd_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop;
  entry_t push_entry, pop_entry;

  itdd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  itdd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  itdd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_o         (pop),
    .pop_entry_i   (pop_entry),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digit_o       (digit_o),
    .digit_count_o (digit_count_o),
    .last_o        (last_o)
  );

endmodule

FILE: rtl/core/itdd_checker.sv
// ----------------------------------------------------------------------------
// itdd_checker
// Port-level checks for integer_to_decimal_digits.
// ----------------------------------------------------------------------------
module itdd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [itdd_pkg::VALUE_W-1:0] value_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [itdd_pkg::DIGIT_W-1:0] digit_o,
  input logic [itdd_pkg::COUNT_W-1:0] digit_count_o,
  input logic                         last_o
);
  import itdd_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ in_ready_o ^ (^value_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(digit_o) && $stable(digit_count_o) && $stable(last_o))
    else $error("output item changed while stalled");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digit_o <= DIGIT_W'(9))
    else $error("digit out of range");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_count_o >= COUNT_W'(1)) && (digit_count_o <= COUNT_W'(21)))
    else $error("digit count out of range");

  a_count_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o && out_ready_i && !last_o) |->
      digit_count_o == $past(digit_count_o))
    else $error("digit count changed within a run");

endmodule

bind integer_to_decimal_digits itdd_checker u_itdd_checker (.*);

FILE: bench/integer_to_decimal_digits_tb.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_digits_tb
// Self-checking bench for the integer to decimal digits converter. A driver
// sends values from a queue with random gaps, and a monitor checks every digit
// against digits worked out locally from each accepted value, under random
// output stalls.
// ----------------------------------------------------------------------------
module integer_to_decimal_digits_tb;

  localparam int unsigned VW = itdd_pkg::VALUE_W;
  localparam int unsigned DW = itdd_pkg::DIGIT_W;
  localparam int unsigned CW = itdd_pkg::COUNT_W;

  localparam longint unsigned BIG_SPLIT  = 64'd10000000000000000;
  localparam longint unsigned SMALL_TOP  = 64'd2147483647;
  localparam longint unsigned DIV_NINE   = 64'd1000000000;
  localparam longint unsigned DIV_EIGHT  = 64'd100000000;
  localparam longint unsigned NOMINAL_HI = 64'd2147483647999999744;
  localparam int              MAX_DIGITS = 21;
  localparam int              WATCHDOG   = 2000;
  localparam int              DRAIN_WAIT = 100;

  typedef struct packed {
    logic [DW-1:0] digit;
    logic [CW-1:0] count;
    logic          last;
  } digit_item_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  logic [VW-1:0] value_i     = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [DW-1:0] digit_o;
  logic [CW-1:0] digit_count_o;
  logic          last_o;

  logic [VW-1:0] value_q[$];
  digit_item_t   pending_digits_q[$];

  logic in_taken = 1'b0;
  logic in_calm  = 1'b0;
  logic out_calm = 1'b0;
  int   in_gap    = 0;
  int   out_stall = 0;
  int   idle_cycles = 0;
  int   errors = 0;
  int   digits_checked = 0;
  int   n_zero = 0, n_small = 0, n_mid = 0, n_big = 0;

  integer_to_decimal_digits u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digit_o       (digit_o),
    .digit_count_o (digit_count_o),
    .last_o        (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Digits of one value, most significant first, pushed as expected items.
  function automatic void predict_digits(input logic [VW-1:0] value);
    longint unsigned v, hi, lo, t;
    int              low_w, hi_w, nd, n;
    logic [DW-1:0]   dig[MAX_DIGITS];
    digit_item_t     item;
    v = 64'(value);
    if (v >= BIG_SPLIT) begin
      hi = v / DIV_NINE;
      lo = v % DIV_NINE;
      low_w = 9;
      n_big++;
    end else if (v > SMALL_TOP) begin
      hi = v / DIV_EIGHT;
      lo = v % DIV_EIGHT;
      low_w = 8;
      n_mid++;
    end else begin
      hi = v;
      lo = 0;
      low_w = 0;
      if (v == 0) n_zero++;
      else n_small++;
    end
    nd = 0;
    t = hi;
    while (t != 0) begin
      t = t / 10;
      nd++;
    end
    hi_w = ((nd + 3) / 4) * 4;
    n = hi_w + low_w;
    for (int i = hi_w - 1; i >= 0; i--) begin
      dig[i] = DW'(hi % 10);
      hi = hi / 10;
    end
    for (int i = low_w - 1; i >= 0; i--) begin
      dig[hi_w + i] = DW'(lo % 10);
      lo = lo / 10;
    end
    for (int k = 0; k < n; k++) begin
      item.digit = dig[k];
      item.count = CW'(n);
      item.last  = (k == n - 1);
      pending_digits_q.push_back(item);
    end
  endfunction

  function automatic logic [VW-1:0] rand_value();
    longint unsigned r, lo_bound;
    int              pick, len;
    r = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick < 3) return r[VW-1:0];
    if (pick == 3) return '0;
    if (pick < 7) begin
      case ($urandom_range(0, 3))
        0: return VW'(SMALL_TOP - 64'($urandom_range(0, 3)) + 64'($urandom_range(0, 3)));
        1: return VW'(BIG_SPLIT - 64'($urandom_range(0, 3)) + 64'($urandom_range(0, 3)));
        2: return VW'(NOMINAL_HI - 64'($urandom_range(0, 1000)));
        default: return VW'(64'($urandom_range(0, 5)) * DIV_NINE * DIV_NINE);
      endcase
    end
    len = $urandom_range(1, 18);
    lo_bound = 1;
    for (int i = 1; i < len; i++) lo_bound = lo_bound * 10;
    return VW'(lo_bound + r % (9 * lo_bound));
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 30) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Driver: new item or gap at each falling edge once the current one is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
    end else if (in_gap > 0) begin
      in_valid_i <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (value_q.size() != 0) begin
      in_valid_i <= 1'b1;
      value_i <= value_q.pop_front();
      in_gap <= in_calm ? 0 : pick_gap();
      if ($urandom_range(0, 19) == 0) in_calm <= !in_calm;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_stall > 0) begin
      out_ready_i <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!out_calm && $urandom_range(0, 5) == 0) out_stall <= pick_gap();
      if ($urandom_range(0, 199) == 0) out_calm <= !out_calm;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    digit_item_t exp_item;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) predict_digits(value_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_digits_q.size() == 0) begin
          report_mismatch($sformatf("digit %0d with no item pending", digit_o));
        end else begin
          exp_item = pending_digits_q.pop_front();
          digits_checked++;
          if (digit_o !== exp_item.digit)
            report_mismatch($sformatf("digit %0d, want %0d", digit_o, exp_item.digit));
          if (digit_count_o !== exp_item.count)
            report_mismatch($sformatf("digit_count %0d, want %0d",
                                      digit_count_o, exp_item.count));
          if (last_o !== exp_item.last)
            report_mismatch($sformatf("last %0b, want %0b", last_o, exp_item.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG);
        $display("integer_to_decimal_digits regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    value_q.push_back(61'd1);
    value_q.push_back(61'd9);
    value_q.push_back(61'd10);
    value_q.push_back(61'd999);
    value_q.push_back(61'd1000);
    value_q.push_back(61'd9999);
    value_q.push_back(61'd10000);
    value_q.push_back(61'd0);
    value_q.push_back(61'd2147483647);
    value_q.push_back(61'd2147483648);
    value_q.push_back(61'd3000000000);
    value_q.push_back(61'd99999999999);
    value_q.push_back(61'd9999999999999999);
    value_q.push_back(61'd10000000000000000);
    value_q.push_back(61'd100000000000000000);
    value_q.push_back(61'd1234567890123456789);
    value_q.push_back(61'd2147483647999999744);
    value_q.push_back(61'h1FFF_FFFF_FFFF_FFFF);
    value_q.push_back(61'h0AAA_AAAA_AAAA_AAAA);
    value_q.push_back(61'h1555_5555_5555_5555);
    value_q.push_back(61'd0);
    value_q.push_back(61'd7);
    for (int i = 0; i < 128; i++) value_q.push_back(rand_value());

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (value_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_digits_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("converted %0d values: %0d zero, %0d up to 2147483647,",
             n_zero + n_small + n_mid + n_big, n_zero, n_small);
    $display("  %0d split by 1e8, %0d split by 1e9; %0d digits checked, %0d mismatches",
             n_mid, n_big, digits_checked, errors);
    if (errors == 0) begin
      $display("integer_to_decimal_digits regression: pass");
    end else begin
      $display("integer_to_decimal_digits regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/itdd_pkg.sv
rtl/core/itdd_front.sv
rtl/core/itdd_fifo.sv
rtl/core/itdd_back.sv
rtl/core/integer_to_decimal_digits.sv
rtl/core/itdd_checker.sv
bench/integer_to_decimal_digits_tb.sv
